FILE: hdl/tset_pkg.sv
// Shared constants and types for the time-slot event table.
package tset_pkg;

    localparam int NUM_SLOT_ROWS = 256;
    localparam int WAYS_PER_SLOT = 8;
    localparam int ROW_W         = $clog2(NUM_SLOT_ROWS);
    localparam int WAY_W         = $clog2(WAYS_PER_SLOT);
    localparam int INDEX_W       = ROW_W + WAY_W;
    localparam int NUM_ENTRIES   = NUM_SLOT_ROWS * WAYS_PER_SLOT;
    localparam int COUNT_W       = $clog2(NUM_ENTRIES + 1);
    localparam int TIME_W        = 32;
    localparam int STATUS_W      = 3;
    localparam int FUNC_W        = 2;

    localparam logic [TIME_W-1:0] SLOT_WIDTH_RESET = 32'h0001_0000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_IGNORED = 3'd1,
        ST_FULL    = 3'd2,
        ST_FREE    = 3'd3,
        ST_BADIDX  = 3'd4
    } status_t;

endpackage

FILE: hdl/tset_div.sv
// Bit-serial restoring divider that returns the low quotient bits (slot row).
module tset_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [tset_pkg::TIME_W-1:0]     dividend,
    input  logic [tset_pkg::TIME_W-1:0]     divisor,
    output logic                            done,
    output logic [tset_pkg::ROW_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(tset_pkg::TIME_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [tset_pkg::TIME_W-1:0]   num_reg;
    logic [tset_pkg::TIME_W-1:0]   den_reg;
    logic [tset_pkg::TIME_W-1:0]   rem_reg;
    logic [tset_pkg::ROW_W-1:0]    quo_reg;

    logic [tset_pkg::TIME_W:0]     rem_shift;
    logic [tset_pkg::TIME_W:0]     rem_diff;
    logic                          q_bit;
    logic [tset_pkg::TIME_W-1:0]   rem_next;

    always_comb begin
        rem_shift = {rem_reg, num_reg[tset_pkg::TIME_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        rem_next  = q_bit ? rem_diff[tset_pkg::TIME_W-1:0] : rem_shift[tset_pkg::TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(tset_pkg::TIME_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[tset_pkg::TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[tset_pkg::ROW_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hdl/time_slot_event_table.sv
// Top level of the time-slot event table: row memory, control sequencer and result register.
//
// Input channel s_*: one beat carries an operation (insert, remove, clear table).
// Result channel m_*: exactly one result beat per input beat, in order.
// Configuration: cfg_wr_en writes slot_width (Q16.16) in the same cycle; write it only
// while the block is idle. Zero width acts as a width of one LSB (2^-16).
// Steps per beat, from accept to result valid:
//   active insert : bit-serial divider for the slot row, then one memory read and one
//                   read-modify-write of the row
//   remove        : row read, modify and write back (an out-of-range index as other)
//   other         : straight to the result register
// One beat is in work at a time; s_ready is high whenever the sequencer is idle, so a
// new beat is taken while a finished result still waits on m_ready.
// A stalled receiver holds the next result at its last step until the result register
// frees up.
// Reset and the clear-table operation drop every row valid bit at once, so all entries
// read as free; no clearing pass is needed. Reset loads slot_width with 1.0.
module time_slot_event_table (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tset_pkg::TIME_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tset_pkg::FUNC_W-1:0]       s_func,
    input  logic [tset_pkg::TIME_W-1:0]       s_event_time,
    input  logic                              s_event_active,
    input  logic [tset_pkg::INDEX_W-1:0]      s_entry_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tset_pkg::INDEX_W-1:0]      m_result_index,
    output logic [tset_pkg::STATUS_W-1:0]     m_status,
    output logic [tset_pkg::COUNT_W-1:0]      m_total_events
);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_READ, S_MOD, S_DONE} state_t;

    state_t                                state_reg;
    tset_pkg::func_t                       func_reg;
    logic [tset_pkg::TIME_W-1:0]           slot_width_reg;
    logic [tset_pkg::ROW_W-1:0]            row_reg;
    logic [tset_pkg::WAY_W-1:0]            way_reg;
    logic [tset_pkg::COUNT_W-1:0]          total_reg;
    logic [tset_pkg::INDEX_W-1:0]          res_index_reg;
    tset_pkg::status_t                     res_status_reg;
    logic [tset_pkg::NUM_SLOT_ROWS-1:0]    row_valid_reg;
    logic [tset_pkg::WAYS_PER_SLOT-1:0]    rd_data_reg;
    logic                                  rd_ok_reg;
    logic                                  m_valid_reg;
    logic [tset_pkg::INDEX_W-1:0]          m_index_reg;
    logic [tset_pkg::STATUS_W-1:0]         m_status_reg;
    logic [tset_pkg::COUNT_W-1:0]          m_total_reg;

    logic [tset_pkg::WAYS_PER_SLOT-1:0]    row_mem [tset_pkg::NUM_SLOT_ROWS];

    logic                                  accept;
    logic                                  out_free;
    logic                                  div_start;
    logic                                  div_done;
    logic [tset_pkg::ROW_W-1:0]            div_row;
    logic [tset_pkg::TIME_W-1:0]           width_eff;
    tset_pkg::func_t                       in_func;
    logic                                  in_range;
    logic [tset_pkg::WAYS_PER_SLOT-1:0]    cur_bits;
    logic                                  free_found;
    logic [tset_pkg::WAY_W-1:0]            free_way;
    logic                                  wr_en;
    logic [tset_pkg::WAYS_PER_SLOT-1:0]    wr_data;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign in_func   = tset_pkg::func_t'(s_func);
    assign in_range  = ({1'b0, s_entry_index} <
                        (tset_pkg::INDEX_W + 1)'(tset_pkg::NUM_ENTRIES));
    assign width_eff = (slot_width_reg == '0) ? tset_pkg::TIME_W'(1) : slot_width_reg;
    assign div_start = accept && (in_func == tset_pkg::FUNC_INSERT) && s_event_active;
    assign cur_bits  = rd_ok_reg ? rd_data_reg : '0;

    tset_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_event_time),
        .divisor  (width_eff),
        .done     (div_done),
        .quotient (div_row)
    );

    always_comb begin
        free_found = 1'b0;
        free_way   = '0;
        for (int w = tset_pkg::WAYS_PER_SLOT - 1; w >= 0; w--) begin
            if (!cur_bits[w]) begin
                free_found = 1'b1;
                free_way   = tset_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_data = cur_bits;
        if (state_reg == S_MOD) begin
            if (func_reg == tset_pkg::FUNC_INSERT) begin
                wr_en             = free_found;
                wr_data[free_way] = 1'b1;
            end else begin
                wr_en            = cur_bits[way_reg];
                wr_data[way_reg] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            row_mem[row_reg] <= wr_data;
        end
        if (state_reg == S_READ) begin
            rd_data_reg <= row_mem[row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slot_width_reg <= tset_pkg::SLOT_WIDTH_RESET;
            total_reg      <= '0;
            row_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slot_width_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        func_reg      <= in_func;
                        row_reg       <= s_entry_index[tset_pkg::INDEX_W-1:tset_pkg::WAY_W];
                        way_reg       <= s_entry_index[tset_pkg::WAY_W-1:0];
                        res_index_reg <= '0;
                        case (in_func)
                            tset_pkg::FUNC_INSERT: begin
                                if (s_event_active) begin
                                    state_reg <= S_DIV;
                                end else begin
                                    res_status_reg <= tset_pkg::ST_IGNORED;
                                    state_reg      <= S_DONE;
                                end
                            end
                            tset_pkg::FUNC_REMOVE: begin
                                if (in_range) begin
                                    state_reg <= S_READ;
                                end else begin
                                    res_status_reg <= tset_pkg::ST_BADIDX;
                                    state_reg      <= S_DONE;
                                end
                            end
                            tset_pkg::FUNC_CLEAR: begin
                                row_valid_reg  <= '0;
                                total_reg      <= '0;
                                res_status_reg <= tset_pkg::ST_OK;
                                state_reg      <= S_DONE;
                            end
                            default: begin
                                res_status_reg <= tset_pkg::ST_IGNORED;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        row_reg   <= div_row;
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    rd_ok_reg <= row_valid_reg[row_reg];
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    if (wr_en) begin
                        row_valid_reg[row_reg] <= 1'b1;
                        res_status_reg         <= tset_pkg::ST_OK;
                        if (func_reg == tset_pkg::FUNC_INSERT) begin
                            total_reg     <= total_reg + tset_pkg::COUNT_W'(1);
                            res_index_reg <= {row_reg, free_way};
                        end else begin
                            total_reg <= total_reg - tset_pkg::COUNT_W'(1);
                        end
                    end else if (func_reg == tset_pkg::FUNC_INSERT) begin
                        res_status_reg <= tset_pkg::ST_FULL;
                    end else begin
                        res_status_reg <= tset_pkg::ST_FREE;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_index_reg  <= res_index_reg;
                        m_status_reg <= res_status_reg;
                        m_total_reg  <= total_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_index_reg;
    assign m_status       = m_status_reg;
    assign m_total_events = m_total_reg;

endmodule

FILE: hdl/tset_checker.sv
// Port-level checker for the time-slot event table, bound to the top level.
module tset_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [tset_pkg::INDEX_W-1:0]      m_result_index,
    input logic [tset_pkg::STATUS_W-1:0]     m_status,
    input logic [tset_pkg::COUNT_W-1:0]      m_total_events
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_index) &&
        $stable(m_status) && $stable(m_total_events))
        else $error("result beat changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != tset_pkg::ST_OK) |-> (m_result_index == '0))
        else $error("nonzero index on failed operation");

    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_total_events <= tset_pkg::COUNT_W'(tset_pkg::NUM_ENTRIES)) &&
        (m_status <= tset_pkg::STATUS_W'(tset_pkg::ST_BADIDX)))
        else $error("total or status out of range");

endmodule

bind time_slot_event_table tset_checker u_tset_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_index (m_result_index),
    .m_status       (m_status),
    .m_total_events (m_total_events)
);
